>>> hdl/pstf_pkg.sv
`default_nettype none

package pstf_pkg;

  // default sample width of one channel
  localparam int SAMPLE_BITS_DEF = 16;

  // widths of the configuration registers and of the frame counter
  localparam int FADE_W  = 31;
  localparam int LIMIT_W = 24;
  localparam int INDEX_W = 32;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LEADING  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd3;

  // command from the control FSM to a fade lane
  typedef struct packed {
    logic              start;
    logic [FADE_W-1:0] num;
    logic [FADE_W-1:0] den;
  } lane_cmd_t;

endpackage

`default_nettype wire

>>> hdl/pstf_lane.sv
`default_nettype none

// One channel of the fade: sample * num / den, truncated toward zero.
// Bit-serial shift-add multiply (one bit of num per cycle), then restoring
// division (one quotient bit per cycle) in the same accumulator.
module pstf_lane #(
  parameter int SB = pstf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pstf_pkg::lane_cmd_t cmd,
  input  logic [SB-1:0]       sample,
  output logic [SB-1:0]       result,
  output logic                done
);

  localparam int NW    = pstf_pkg::FADE_W;
  localparam int PW    = SB + NW;
  localparam int STEPS = NW + SB;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    acc;
  logic [NW-1:0]    num_sh;
  logic [NW-1:0]    den;
  logic [SB-1:0]    mag;
  logic             neg;

  logic [PW-1:0]    mul_next;
  logic [NW:0]      trial;
  logic [NW:0]      diff;
  logic             ge;
  logic [NW-1:0]    new_rem;
  logic [PW-1:0]    div_next;
  logic             in_mul;
  logic [SB-1:0]    quot;

  // multiply step: shift and add magnitude on a set bit of num, MSB first
  assign mul_next = {acc[PW-2:0], 1'b0} + (num_sh[NW-1] ? PW'(mag) : '0);

  // divide step: remainder in the top, quotient bits enter at the bottom
  assign trial    = {acc[PW-1:SB], acc[SB-1]};
  assign diff     = trial - {1'b0, den};
  assign ge       = (trial >= {1'b0, den});
  assign new_rem  = ge ? diff[NW-1:0] : trial[NW-1:0];
  assign div_next = {new_rem, acc[SB-2:0], ge};

  assign in_mul = (cnt < CNT_W'(NW));
  assign quot   = div_next[SB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        num_sh <= cmd.num;
        den    <= cmd.den;
        neg    <= sample[SB-1];
        mag    <= sample[SB-1] ? (~sample + SB'(1)) : sample;
      end else if (busy) begin
        if (in_mul) begin
          acc    <= mul_next;
          num_sh <= {num_sh[NW-2:0], 1'b0};
        end else begin
          acc <= div_next;
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          // zero divisor gives zero
          if (den == '0) begin
            result <= '0;
          end else begin
            result <= neg ? (~quot + SB'(1)) : quot;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pcm_silence_trim_and_fade_out_core.sv
`default_nettype none

// Stereo PCM leading-silence trim and linear fade-out. One frame (left_in,
// right_in) is taken per word; each word gives zero or one result word.
// A dropped leading silent frame gives no word, but one that times out gives
// a zero word with silent_timeout set. A frame that needs no scaling goes to
// the pending register and then to the output register. A frame inside the
// fade is scaled by the two bit-serial lanes, which run a 31-step shift-add
// multiply and a SAMPLE_BITS-step restoring divide, and then takes the same
// path. The next word is taken once the result has left the pending register.
// One frame is in work at a time. The next is accepted while a result waits
// in the output register, and a stalled output holds the following result in
// the pending register. Configuration is written through cfg_we / cfg_index /
// cfg_data (0 song_length, 1 fade_length, 2 trim_leading, 3 silence_limit).
// The user must write it only while idle; the block itself does not enforce this.
module pcm_silence_trim_and_fade_out_core #(
  parameter int SAMPLE_BITS = pstf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [pstf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pstf_pkg::CFG_W-1:0]          cfg_data,
  // input frames
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       left_in,
  input  logic signed [SAMPLE_BITS-1:0]       right_in,
  // result frames
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       left_out,
  output logic signed [SAMPLE_BITS-1:0]       right_out,
  output logic                                last_frame,
  output logic                                silent_timeout
);

  localparam int FW = pstf_pkg::FADE_W;
  localparam int LW = pstf_pkg::LIMIT_W;
  localparam int IW = pstf_pkg::INDEX_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state;

  // configuration registers
  logic [FW-1:0] song_length;
  logic [FW-1:0] fade_length;
  logic          trim_leading;
  logic [LW-1:0] silence_limit;

  // stream state
  logic [IW-1:0] frame_index;
  logic [LW-1:0] silent_count;
  logic          in_leading_phase;
  logic          finished;

  // pending result
  logic [SAMPLE_BITS-1:0] pend_l;
  logic [SAMPLE_BITS-1:0] pend_r;
  logic                   pend_last;
  logic                   pend_to;

  // accept decision
  logic          accept;
  logic          silent;
  logic          drop_phase;
  logic [LW-1:0] count_next;
  logic          timeout;
  logic [IW-1:0] total;
  logic [IW-1:0] num_full;
  logic          at_end;
  logic          is_last;
  logic          need_fade;
  logic          out_free;

  pstf_pkg::lane_cmd_t    lane_cmd;
  logic [SAMPLE_BITS-1:0] lane_l;
  logic [SAMPLE_BITS-1:0] lane_r;
  logic                   done_l;
  logic                   done_r;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign silent     = (left_in == '0) && (right_in == '0);
  assign drop_phase = in_leading_phase && trim_leading && silent;
  assign count_next = (silent_count == {LW{1'b1}}) ? silent_count
                                                   : silent_count + LW'(1);
  assign timeout    = (count_next >= silence_limit);

  assign total     = IW'(song_length) + IW'(fade_length);
  assign num_full  = total - frame_index;
  assign at_end    = (frame_index >= total);
  assign is_last   = (frame_index == total - IW'(1));
  assign need_fade = (frame_index > IW'(song_length));

  // lanes start on a frame inside the fade
  always_comb begin
    lane_cmd.start = accept && !finished && !drop_phase && !at_end && need_fade;
    lane_cmd.num   = num_full[FW-1:0];
    lane_cmd.den   = fade_length;
  end

  pstf_lane #(.SB(SAMPLE_BITS)) u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .cmd    (lane_cmd),
    .sample (left_in),
    .result (lane_l),
    .done   (done_l)
  );

  pstf_lane #(.SB(SAMPLE_BITS)) u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .cmd    (lane_cmd),
    .sample (right_in),
    .result (lane_r),
    .done   (done_r)
  );

  // configuration write decoder
  always_ff @(posedge clk) begin
    if (rst) begin
      song_length   <= '0;
      fade_length   <= '0;
      trim_leading  <= 1'b0;
      silence_limit <= LW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pstf_pkg::REG_SONG_LENGTH:   song_length   <= cfg_data[FW-1:0];
        pstf_pkg::REG_FADE_LENGTH:   fade_length   <= cfg_data[FW-1:0];
        pstf_pkg::REG_TRIM_LEADING:  trim_leading  <= cfg_data[0];
        pstf_pkg::REG_SILENCE_LIMIT: silence_limit <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // control FSM and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      frame_index      <= '0;
      silent_count     <= '0;
      in_leading_phase <= 1'b1;
      finished         <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && !finished) begin
            if (drop_phase) begin
              // leading silent frame: count, maybe time out
              silent_count <= count_next;
              if (timeout) begin
                finished  <= 1'b1;
                pend_l    <= '0;
                pend_r    <= '0;
                pend_last <= 1'b0;
                pend_to   <= 1'b1;
                state     <= ST_HOLD;
              end
            end else begin
              in_leading_phase <= 1'b0;
              if (at_end) begin
                finished <= 1'b1;
              end else begin
                frame_index <= frame_index + IW'(1);
                pend_last   <= is_last;
                pend_to     <= 1'b0;
                if (is_last) begin
                  finished <= 1'b1;
                end
                if (need_fade) begin
                  state <= ST_CALC;
                end else begin
                  pend_l <= left_in;
                  pend_r <= right_in;
                  state  <= ST_HOLD;
                end
              end
            end
          end
        end
        ST_CALC: begin
          if (done_l && done_r) begin
            pend_l <= lane_l;
            pend_r <= lane_r;
            state  <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid      <= 1'b1;
      left_out       <= pend_l;
      right_out      <= pend_r;
      last_frame     <= pend_last;
      silent_timeout <= pend_to;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
